// ----- rtl/core/best_fit_range_allocator_unit_macros.svh -----
// Assertion helpers; expect i_clk and i_rst_n in scope.
`ifndef BEST_FIT_RANGE_ALLOCATOR_UNIT_MACROS_SVH
`define BEST_FIT_RANGE_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define BFRA_ASSERT_NOW(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define BFRA_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/core/bfra_pkg.sv -----
package bfra_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int DATA_W     = 32;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;
    localparam logic [DATA_W-1:0] HEAP_RST = 32'd65536;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] off;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] age;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              best_found;
        logic [IDX_W-1:0]  best_idx;
        logic [DATA_W-1:0] best_off;
        logic [DATA_W-1:0] best_size;
        logic [DATA_W-1:0] best_age;
        logic              hit;
        logic              prev_found;
        logic [IDX_W-1:0]  prev_idx;
        logic [DATA_W-1:0] prev_off;
        logic [DATA_W-1:0] prev_size;
        logic              next_found;
        logic [IDX_W-1:0]  next_idx;
        logic [DATA_W-1:0] next_off;
        logic [DATA_W-1:0] next_size;
        logic              slot_found;
        logic [IDX_W-1:0]  slot_idx;
    } t_scan;

    // saturating add of two unsigned words
    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DATA_W] ? ALL_ONES : s[DATA_W-1:0];
    endfunction

endpackage

// ----- rtl/core/bfra_ram.sv -----
module bfra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/bfra_scan.sv -----
module bfra_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_en,
    input  logic [bfra_pkg::IDX_W-1:0]   i_idx,
    input  logic                         i_entry_valid,
    input  bfra_pkg::t_entry             i_entry,
    input  logic                         i_func,
    input  logic [bfra_pkg::DATA_W-1:0]  i_off,
    input  logic [bfra_pkg::DATA_W-1:0]  i_size,
    output bfra_pkg::t_scan              o_res
);

    bfra_pkg::t_scan r_res;
    bfra_pkg::t_scan n_res;

    always_comb begin
        n_res = r_res;
        if (i_start) begin
            n_res.best_found = 1'b0;
            n_res.hit        = 1'b0;
            n_res.prev_found = 1'b0;
            n_res.next_found = 1'b0;
            n_res.slot_found = 1'b0;
        end else if (i_en) begin
            if (!i_entry_valid) begin
                if (!r_res.slot_found) begin
                    n_res.slot_found = 1'b1;
                    n_res.slot_idx   = i_idx;
                end
            end else if (i_func == bfra_pkg::FUNC_ALLOC) begin
                // smallest fit, oldest among equal sizes
                if (i_entry.size >= i_size &&
                    (!r_res.best_found || i_entry.size < r_res.best_size ||
                     (i_entry.size == r_res.best_size && i_entry.age < r_res.best_age))) begin
                    n_res.best_found = 1'b1;
                    n_res.best_idx   = i_idx;
                    n_res.best_off   = i_entry.off;
                    n_res.best_size  = i_entry.size;
                    n_res.best_age   = i_entry.age;
                end
            end else begin
                priority if (i_entry.off == i_off) begin
                    n_res.hit = 1'b1;
                end else if (i_entry.off < i_off) begin
                    if (!r_res.prev_found || i_entry.off > r_res.prev_off) begin
                        n_res.prev_found = 1'b1;
                        n_res.prev_idx   = i_idx;
                        n_res.prev_off   = i_entry.off;
                        n_res.prev_size  = i_entry.size;
                    end
                end else begin
                    if (!r_res.next_found || i_entry.off < r_res.next_off) begin
                        n_res.next_found = 1'b1;
                        n_res.next_idx   = i_idx;
                        n_res.next_off   = i_entry.off;
                        n_res.next_size  = i_entry.size;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ----- rtl/core/best_fit_range_allocator_unit.sv -----
// Best-fit range allocator over a free table of MAX_BLOCKS entries.
// Input channel (i_valid/o_ready): i_func selects allocate or free, with
// i_offset and i_size. Output channel (o_valid/i_ready) returns one
// transaction per request: o_result_offset and o_status.
// A request that needs the table scans every entry once through one
// compare unit, one entry per cycle from the table RAM, then decides and
// writes back; the write-back is skipped when no entry is written (exact
// fit, no fit, existing start, table full). Allocations larger than the
// free total and zero-size frees skip the scan and go straight to output.
// One request is in flight at a time; o_ready is high only when the
// sequencer is idle, so the next request is accepted at the earliest in
// the cycle after the previous result is loaded.
// The result sits in an output register; if the receiver stalls, a
// finished request waits in the sequencer until that register is free.
// Reset or a write of i_cfg_wr_data (heap size) clears the table and
// enters a seeding state that writes the single block covering the heap
// (valid only for a nonzero heap); o_ready stays low while seeding.
`include "best_fit_range_allocator_unit_macros.svh"

module best_fit_range_allocator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [bfra_pkg::DATA_W-1:0]  i_cfg_wr_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_func,
    input  logic [bfra_pkg::DATA_W-1:0]  i_offset,
    input  logic [bfra_pkg::DATA_W-1:0]  i_size,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bfra_pkg::DATA_W-1:0]  o_result_offset,
    output logic [1:0]                   o_status
);

    localparam logic [2:0] ST_SEED   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_WRITE  = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    localparam int DW = bfra_pkg::DATA_W;
    localparam int IW = bfra_pkg::IDX_W;
    localparam int CW = bfra_pkg::CNT_W;

    logic [2:0]                       r_state, n_state;
    logic [DW-1:0]                    r_heap, n_heap;
    logic [DW-1:0]                    r_free_total, n_free_total;
    logic [DW-1:0]                    r_counter, n_counter;
    logic [bfra_pkg::MAX_BLOCKS-1:0]  r_valid, n_valid;
    logic                             r_func, n_func;
    logic [DW-1:0]                    r_off, n_off;
    logic [DW-1:0]                    r_size, n_size;
    logic [DW:0]                      r_end, n_end;
    logic [CW-1:0]                    r_idx, n_idx;
    logic                             r_cmp_en, n_cmp_en;
    logic [IW-1:0]                    r_cmp_idx, n_cmp_idx;
    logic [IW-1:0]                    r_wr_idx, n_wr_idx;
    logic [DW-1:0]                    r_wr_off, n_wr_off;
    logic [DW-1:0]                    r_wa, n_wa;
    logic [DW-1:0]                    r_wb, n_wb;
    logic [DW-1:0]                    r_wc, n_wc;
    logic [DW-1:0]                    r_pend_off, n_pend_off;
    logic [1:0]                       r_pend_stat, n_pend_stat;
    logic                             r_o_valid, n_o_valid;
    logic [DW-1:0]                    r_o_off, n_o_off;
    logic [1:0]                       r_o_stat, n_o_stat;

    logic                    w_ram_we;
    logic [IW-1:0]           w_ram_waddr;
    bfra_pkg::t_entry        w_ram_wdata;
    logic [IW-1:0]           w_ram_raddr;
    logic [bfra_pkg::ENTRY_W-1:0] w_ram_rbits;
    bfra_pkg::t_entry        w_ram_rdata;
    logic                    w_scan_start;
    bfra_pkg::t_scan         w_scan;
    logic [DW+1:0]           w_sum;
    logic [DW-1:0]           w_sum_sat;
    logic                    w_merge_prev;
    logic                    w_merge_next;
    logic [IW-1:0]           w_idx_lo;

    assign o_ready      = (r_state == ST_IDLE);
    assign w_scan_start = o_ready & i_valid;
    assign w_idx_lo     = r_idx[IW-1:0];
    assign w_ram_rdata  = w_ram_rbits;

    assign w_sum     = {2'b00, r_wa} + {2'b00, r_wb} + {2'b00, r_wc};
    assign w_sum_sat = (|w_sum[DW+1:DW]) ? bfra_pkg::ALL_ONES : w_sum[DW-1:0];

    assign w_merge_prev = w_scan.prev_found &&
        (({1'b0, w_scan.prev_off} + {1'b0, w_scan.prev_size}) == {1'b0, r_off});
    assign w_merge_next = w_scan.next_found && (r_end == {1'b0, w_scan.next_off});

    bfra_ram #(
        .WIDTH (bfra_pkg::ENTRY_W),
        .DEPTH (bfra_pkg::MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rbits)
    );

    bfra_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_scan_start),
        .i_en          (r_cmp_en),
        .i_idx         (r_cmp_idx),
        .i_entry_valid (r_valid[r_cmp_idx]),
        .i_entry       (w_ram_rdata),
        .i_func        (r_func),
        .i_off         (r_off),
        .i_size        (r_size),
        .o_res         (w_scan)
    );

    always_comb begin
        n_state      = r_state;
        n_heap       = r_heap;
        n_free_total = r_free_total;
        n_counter    = r_counter;
        n_valid      = r_valid;
        n_func       = r_func;
        n_off        = r_off;
        n_size       = r_size;
        n_end        = r_end;
        n_idx        = r_idx;
        n_cmp_en     = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_wr_idx     = r_wr_idx;
        n_wr_off     = r_wr_off;
        n_wa         = r_wa;
        n_wb         = r_wb;
        n_wc         = r_wc;
        n_pend_off   = r_pend_off;
        n_pend_stat  = r_pend_stat;
        n_o_valid    = r_o_valid;
        n_o_off      = r_o_off;
        n_o_stat     = r_o_stat;
        w_ram_we     = 1'b0;
        w_ram_waddr  = r_wr_idx;
        w_ram_wdata  = '{off: r_wr_off, size: w_sum_sat, age: r_counter};
        w_ram_raddr  = w_idx_lo;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            ST_SEED: begin
                w_ram_we     = 1'b1;
                w_ram_waddr  = '0;
                w_ram_wdata  = '{off: '0, size: r_heap, age: '0};
                n_valid      = '0;
                n_valid[0]   = (r_heap != '0);
                n_counter    = {{(DW-1){1'b0}}, 1'b1};
                n_free_total = r_heap;
                n_state      = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_func = i_func;
                    n_off  = i_offset;
                    n_size = i_size;
                    n_end  = {1'b0, i_offset} + {1'b0, i_size};
                    n_idx  = '0;
                    priority if (i_func == bfra_pkg::FUNC_ALLOC && r_free_total < i_size) begin
                        n_pend_off  = bfra_pkg::ALL_ONES;
                        n_pend_stat = bfra_pkg::STAT_NOFIT;
                        n_state     = ST_OUT;
                    end else if (i_func == bfra_pkg::FUNC_FREE && i_size == '0) begin
                        n_pend_off  = '0;
                        n_pend_stat = bfra_pkg::STAT_OK;
                        n_state     = ST_OUT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx != CW'(bfra_pkg::MAX_BLOCKS)) begin
                    n_cmp_en  = 1'b1;
                    n_cmp_idx = w_idx_lo;
                    n_idx     = r_idx + 1'b1;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_wc = '0;
                if (r_func == bfra_pkg::FUNC_ALLOC) begin
                    if (!w_scan.best_found) begin
                        n_pend_off  = bfra_pkg::ALL_ONES;
                        n_pend_stat = bfra_pkg::STAT_NOFIT;
                        n_state     = ST_OUT;
                    end else begin
                        n_pend_off   = w_scan.best_off;
                        n_pend_stat  = bfra_pkg::STAT_OK;
                        n_free_total = r_free_total - r_size;
                        n_wr_idx     = w_scan.best_idx;
                        n_wr_off     = w_scan.best_off + r_size;
                        n_wa         = w_scan.best_size - r_size;
                        n_wb         = '0;
                        if (w_scan.best_size == r_size) begin
                            n_valid[w_scan.best_idx] = 1'b0;
                            n_state = ST_OUT;
                        end else begin
                            n_state = ST_WRITE;
                        end
                    end
                end else begin
                    n_pend_off  = '0;
                    n_pend_stat = bfra_pkg::STAT_OK;
                    priority if (w_scan.hit) begin
                        n_pend_stat = bfra_pkg::STAT_NOFIT;
                        n_state     = ST_OUT;
                    end else if (w_merge_prev) begin
                        n_wr_idx = w_scan.prev_idx;
                        n_wr_off = w_scan.prev_off;
                        n_wa     = w_scan.prev_size;
                        n_wb     = r_size;
                        if (w_merge_next) begin
                            n_wc = w_scan.next_size;
                            n_valid[w_scan.next_idx] = 1'b0;
                        end
                        n_state = ST_WRITE;
                    end else if (w_merge_next) begin
                        n_wr_idx = w_scan.next_idx;
                        n_wr_off = r_off;
                        n_wa     = r_size;
                        n_wb     = w_scan.next_size;
                        n_state  = ST_WRITE;
                    end else if (w_scan.slot_found) begin
                        n_wr_idx = w_scan.slot_idx;
                        n_wr_off = r_off;
                        n_wa     = r_size;
                        n_wb     = '0;
                        n_state  = ST_WRITE;
                    end else begin
                        n_pend_stat = bfra_pkg::STAT_FULL;
                        n_state     = ST_OUT;
                    end
                end
            end
            ST_WRITE: begin
                w_ram_we          = 1'b1;
                n_valid[r_wr_idx] = 1'b1;
                n_counter         = r_counter + 1'b1;
                if (r_func == bfra_pkg::FUNC_FREE) begin
                    n_free_total = bfra_pkg::sat_add(r_free_total, r_size);
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_off   = r_pend_off;
                    n_o_stat  = r_pend_stat;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_SEED;
            end
        endcase

        if (i_cfg_wr_en) begin
            n_heap  = i_cfg_wr_data;
            n_state = ST_SEED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SEED;
            r_heap       <= bfra_pkg::HEAP_RST;
            r_free_total <= bfra_pkg::HEAP_RST;
            r_counter    <= {{(DW-1){1'b0}}, 1'b1};
            r_valid      <= '0;
            r_cmp_en     <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_heap       <= n_heap;
            r_free_total <= n_free_total;
            r_counter    <= n_counter;
            r_valid      <= n_valid;
            r_cmp_en     <= n_cmp_en;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_off       <= n_off;
        r_size      <= n_size;
        r_end       <= n_end;
        r_idx       <= n_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_wr_idx    <= n_wr_idx;
        r_wr_off    <= n_wr_off;
        r_wa        <= n_wa;
        r_wb        <= n_wb;
        r_wc        <= n_wc;
        r_pend_off  <= n_pend_off;
        r_pend_stat <= n_pend_stat;
        r_o_off     <= n_o_off;
        r_o_stat    <= n_o_stat;
    end

    assign o_valid         = r_o_valid;
    assign o_result_offset = r_o_off;
    assign o_status        = r_o_stat;

    `BFRA_ASSERT_NOW(a_write_after_decide, r_state == ST_WRITE, $past(r_state) == ST_DECIDE, "write-back not preceded by decision")
    `BFRA_ASSERT_NOW(a_cmp_follows_issue, r_cmp_en, r_cmp_idx == $past(w_idx_lo), "compare index does not match issued read")
    `BFRA_ASSERT_NEXT(a_age_advance, r_state == ST_WRITE, r_counter == $past(r_counter) + 32'd1, "insert counter not advanced on write-back")
    `BFRA_ASSERT_NOW(a_result_from_out, $rose(o_valid), $past(r_state) == ST_OUT, "result presented outside output state")

endmodule
